>>> src/tkps_pkg.sv
// Package for the per-sector top-K selector: request/response payload types and opcodes.
// Depends on nothing; used by top_k_per_sector_selector.
package tkps_pkg;

   localparam int unsigned SECTOR_W   = 6;
   localparam int unsigned STRENGTH_W = 16;
   localparam int unsigned POINT_W    = 16;
   localparam int unsigned OPCODE_W   = 2;

   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0]          opcode;
      logic [SECTOR_W-1:0]          sector;
      logic [STRENGTH_W-1:0]        strength;
      logic signed [POINT_W-1:0]    point_x;
      logic signed [POINT_W-1:0]    point_y;
   } req_type;

   typedef struct packed {
      logic                         valid_res;
      logic signed [POINT_W-1:0]    out_x;
      logic signed [POINT_W-1:0]    out_y;
      logic [SECTOR_W-1:0]          out_sector;
      logic                         last;
   } rsp_type;

endpackage

>>> src/top_k_per_sector_selector.sv
// Per-sector top-K selector: top level with sequencer, per-sector fill counts and row RAM.
// Depends on tkps_pkg and tkps_ram.
//
// Requests are taken when start is high and busy is low. An insert reads the sector row
// from RAM, then writes back the re-ranked row. For a read, the sequencer walks one sector
// per cycle through the fill counts, first to the next kept point and then on to decide the
// last flag. Each read yields one response, shown for one cycle under rsp_strobe; the
// receiver cannot stall it and must take it then. Clear and insert give no response.
module top_k_per_sector_selector #(
   parameter int unsigned NUM_SECTORS     = 48,
   parameter int unsigned KEEP_PER_SECTOR = 4,
   parameter int unsigned COORD_WIDTH     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tkps_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tkps_pkg::rsp_type rsp_data
);

   localparam int unsigned SW   = tkps_pkg::STRENGTH_W;
   localparam int unsigned PW   = tkps_pkg::POINT_W;
   localparam int unsigned EW   = SW + 2 * COORD_WIDTH;
   localparam int unsigned RW   = KEEP_PER_SECTOR * EW;
   localparam int unsigned SIW  = $clog2(NUM_SECTORS);
   localparam int unsigned SCW  = $clog2(NUM_SECTORS + 1);
   localparam int unsigned CNW  = $clog2(KEEP_PER_SECTOR + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_INS  = 2'd1;
   localparam logic [1:0] ST_SEEK = 2'd2;
   localparam logic [1:0] ST_LAST = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CNW-1:0]         cnt_ff [NUM_SECTORS];
   logic [SCW-1:0]         rd_sec_ff, rd_sec_in;
   logic [CNW-1:0]         rd_slot_ff, rd_slot_in;
   logic [SCW-1:0]         cur_sec_ff, cur_sec_in;
   logic [CNW-1:0]         cur_slot_ff, cur_slot_in;
   logic [SCW-1:0]         hit_sec_ff, hit_sec_in;
   logic [CNW-1:0]         hit_slot_ff, hit_slot_in;
   logic [SIW-1:0]         ins_sec_ff, ins_sec_in;
   logic [SW-1:0]          ins_str_ff, ins_str_in;
   logic [COORD_WIDTH-1:0] ins_x_ff, ins_x_in;
   logic [COORD_WIDTH-1:0] ins_y_ff, ins_y_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   tkps_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   cnt_clear;
   logic                   cnt_wr;
   logic [CNW-1:0]         cnt_new;

   logic                   ram_wr_en;
   logic [RW-1:0]          ram_wr_data;
   logic                   ram_rd_en;
   logic [SIW-1:0]         ram_rd_addr;
   logic [RW-1:0]          ram_rd_data;

   logic                   cur_in_range;
   logic [CNW-1:0]         cur_cnt;
   logic                   cur_hit;
   logic [CNW-1:0]         ins_cnt;
   logic [CNW-1:0]         ins_pos;
   logic [EW-1:0]          ins_entry;
   logic [RW-1:0]          shifted_row;
   logic [EW-1:0]          hit_entry;
   logic [COORD_WIDTH+PW-1:0] hit_x_ext;
   logic [COORD_WIDTH+PW-1:0] hit_y_ext;
   logic [COORD_WIDTH+PW-1:0] req_x_ext;
   logic [COORD_WIDTH+PW-1:0] req_y_ext;
   logic                   req_in_range;

   tkps_ram #(
      .WIDTH (RW),
      .DEPTH (NUM_SECTORS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ins_sec_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cur_in_range = cur_sec_ff < SCW'(NUM_SECTORS);
   assign cur_cnt      = cur_in_range ? cnt_ff[cur_sec_ff[SIW-1:0]] : '0;
   assign cur_hit      = cur_in_range && (cur_slot_ff < cur_cnt);
   assign ins_cnt      = cnt_ff[ins_sec_ff];
   assign req_in_range = 8'(req_data.sector) < 8'(NUM_SECTORS);
   assign req_x_ext    = {{COORD_WIDTH{1'b0}}, req_data.point_x};
   assign req_y_ext    = {{COORD_WIDTH{1'b0}}, req_data.point_y};
   assign ins_entry    = {ins_str_ff, ins_x_ff, ins_y_ff};
   assign shifted_row  = ram_rd_data << EW;

   always_comb begin
      ins_pos = CNW'(KEEP_PER_SECTOR);
      for (int k = KEEP_PER_SECTOR - 1; k >= 0; k--) begin
         if ((CNW'(k) >= ins_cnt) ||
             (ram_rd_data[k*EW + 2*COORD_WIDTH +: SW] < ins_str_ff)) begin
            ins_pos = CNW'(k);
         end
      end
      for (int k = 0; k < KEEP_PER_SECTOR; k++) begin
         if (CNW'(k) < ins_pos) begin
            ram_wr_data[k*EW +: EW] = ram_rd_data[k*EW +: EW];
         end else if (CNW'(k) == ins_pos) begin
            ram_wr_data[k*EW +: EW] = ins_entry;
         end else begin
            ram_wr_data[k*EW +: EW] = shifted_row[k*EW +: EW];
         end
      end
      cnt_new = (ins_cnt < CNW'(KEEP_PER_SECTOR)) ? ins_cnt + 1'b1 : ins_cnt;
   end

   always_comb begin
      hit_entry = ram_rd_data[EW-1:0];
      for (int k = 0; k < KEEP_PER_SECTOR; k++) begin
         if (hit_slot_ff == CNW'(k)) begin
            hit_entry = ram_rd_data[k*EW +: EW];
         end
      end
      hit_x_ext = {{PW{1'b0}}, hit_entry[2*COORD_WIDTH-1:COORD_WIDTH]};
      hit_y_ext = {{PW{1'b0}}, hit_entry[COORD_WIDTH-1:0]};
   end

   always_comb begin
      state_in      = state_ff;
      rd_sec_in     = rd_sec_ff;
      rd_slot_in    = rd_slot_ff;
      cur_sec_in    = cur_sec_ff;
      cur_slot_in   = cur_slot_ff;
      hit_sec_in    = hit_sec_ff;
      hit_slot_in   = hit_slot_ff;
      ins_sec_in    = ins_sec_ff;
      ins_str_in    = ins_str_ff;
      ins_x_in      = ins_x_ff;
      ins_y_in      = ins_y_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      cnt_clear     = 1'b0;
      cnt_wr        = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = SIW'(req_data.sector);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.opcode)
                  tkps_pkg::OP_CLEAR: begin
                     cnt_clear  = 1'b1;
                     rd_sec_in  = '0;
                     rd_slot_in = '0;
                  end
                  tkps_pkg::OP_INSERT: begin
                     if (req_in_range) begin
                        ram_rd_en  = 1'b1;
                        ins_sec_in = SIW'(req_data.sector);
                        ins_str_in = req_data.strength;
                        ins_x_in   = req_x_ext[COORD_WIDTH-1:0];
                        ins_y_in   = req_y_ext[COORD_WIDTH-1:0];
                        state_in   = ST_INS;
                     end
                  end
                  tkps_pkg::OP_READ: begin
                     cur_sec_in  = rd_sec_ff;
                     cur_slot_in = rd_slot_ff;
                     state_in    = ST_SEEK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INS: begin
            if (ins_pos < CNW'(KEEP_PER_SECTOR)) begin
               ram_wr_en = 1'b1;
               cnt_wr    = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SEEK: begin
            if (!cur_in_range) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               rd_sec_in     = SCW'(NUM_SECTORS);
               rd_slot_in    = '0;
               state_in      = ST_IDLE;
            end else if (cur_hit) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cur_sec_ff[SIW-1:0];
               hit_sec_in  = cur_sec_ff;
               hit_slot_in = cur_slot_ff;
               if (cur_slot_ff == CNW'(KEEP_PER_SECTOR - 1)) begin
                  cur_sec_in  = cur_sec_ff + 1'b1;
                  cur_slot_in = '0;
               end else begin
                  cur_slot_in = cur_slot_ff + 1'b1;
               end
               rd_sec_in  = cur_sec_in;
               rd_slot_in = cur_slot_in;
               state_in   = ST_LAST;
            end else begin
               cur_sec_in  = cur_sec_ff + 1'b1;
               cur_slot_in = '0;
            end
         end
         ST_LAST: begin
            if (!cur_in_range || cur_hit) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.valid_res  = 1'b1;
               rsp_in.out_x      = hit_x_ext[PW-1:0];
               rsp_in.out_y      = hit_y_ext[PW-1:0];
               rsp_in.out_sector = tkps_pkg::SECTOR_W'(hit_sec_ff);
               rsp_in.last       = !cur_hit;
               state_in          = ST_IDLE;
            end else begin
               cur_sec_in  = cur_sec_ff + 1'b1;
               cur_slot_in = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_sec_ff     <= '0;
         rd_slot_ff    <= '0;
         cur_sec_ff    <= '0;
         cur_slot_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
         for (int s = 0; s < NUM_SECTORS; s++) begin
            cnt_ff[s] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rd_sec_ff     <= rd_sec_in;
         rd_slot_ff    <= rd_slot_in;
         cur_sec_ff    <= cur_sec_in;
         cur_slot_ff   <= cur_slot_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (cnt_clear) begin
            for (int s = 0; s < NUM_SECTORS; s++) begin
               cnt_ff[s] <= '0;
            end
         end else if (cnt_wr) begin
            cnt_ff[ins_sec_ff] <= cnt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_sec_ff  <= hit_sec_in;
      hit_slot_ff <= hit_slot_in;
      ins_sec_ff  <= ins_sec_in;
      ins_str_ff  <= ins_str_in;
      ins_x_ff    <= ins_x_in;
      ins_y_ff    <= ins_y_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> src/tkps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used by top_k_per_sector_selector for the sector rows.
module tkps_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [WIDTH-1:0]              wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/sv/top_k_per_sector_selector_tb.sv
// Testbench for top_k_per_sector_selector: directed and random clear/insert/read requests,
// with an in-bench ranking store that predicts every read response and checks it per field.
// Depends on tkps_pkg and the selector RTL only.
module top_k_per_sector_selector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SECTORS     = 48;
   localparam int KEEP_PER_SECTOR = 4;
   localparam int RANDOM_REQUESTS = 1750;
   localparam int DRAIN_CYCLES    = 2 * NUM_SECTORS + 20;
   localparam logic [tkps_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   tkps_pkg::req_type req_data;
   logic              rsp_strobe;
   tkps_pkg::rsp_type rsp_data;

   top_k_per_sector_selector #(
      .NUM_SECTORS     (NUM_SECTORS),
      .KEEP_PER_SECTOR (KEEP_PER_SECTOR),
      .COORD_WIDTH     (16)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicted ranking store and read walk position.
   logic                            kept_valid    [NUM_SECTORS][KEEP_PER_SECTOR];
   logic [tkps_pkg::STRENGTH_W-1:0] kept_strength [NUM_SECTORS][KEEP_PER_SECTOR];
   logic [tkps_pkg::POINT_W-1:0]    kept_x        [NUM_SECTORS][KEEP_PER_SECTOR];
   logic [tkps_pkg::POINT_W-1:0]    kept_y        [NUM_SECTORS][KEEP_PER_SECTOR];
   int                              walk_sector;
   int                              walk_slot;

   tkps_pkg::rsp_type expected_points[$];
   tkps_pkg::rsp_type newest_point;

   int mismatches   = 0;
   int requests     = 0;
   int inserts      = 0;
   int reads        = 0;
   int clears       = 0;
   int points_seen  = 0;
   int empty_seen   = 0;
   int burst_left   = 4;

   function automatic void clear_kept();
      for (int s = 0; s < NUM_SECTORS; s++) begin
         for (int k = 0; k < KEEP_PER_SECTOR; k++) begin
            kept_valid[s][k]    = 1'b0;
            kept_strength[s][k] = '0;
            kept_x[s][k]        = '0;
            kept_y[s][k]        = '0;
         end
      end
      walk_sector = 0;
      walk_slot   = 0;
   endfunction

   function automatic bit seek_kept(inout int sec, inout int slt);
      while (sec < NUM_SECTORS) begin
         while (slt < KEEP_PER_SECTOR) begin
            if (kept_valid[sec][slt])
               return 1'b1;
            slt++;
         end
         sec++;
         slt = 0;
      end
      sec = NUM_SECTORS;
      slt = 0;
      return 1'b0;
   endfunction

   function automatic void rank_candidate(input tkps_pkg::req_type r);
      int s;
      int pos;
      s   = int'(r.sector);
      pos = KEEP_PER_SECTOR;
      if (s >= NUM_SECTORS)
         return;
      for (int k = 0; k < KEEP_PER_SECTOR; k++) begin
         if (!kept_valid[s][k] || kept_strength[s][k] < r.strength) begin
            pos = k;
            break;
         end
      end
      if (pos >= KEEP_PER_SECTOR)
         return;
      for (int k = KEEP_PER_SECTOR - 1; k > pos; k--) begin
         kept_valid[s][k]    = kept_valid[s][k-1];
         kept_strength[s][k] = kept_strength[s][k-1];
         kept_x[s][k]        = kept_x[s][k-1];
         kept_y[s][k]        = kept_y[s][k-1];
      end
      kept_valid[s][pos]    = 1'b1;
      kept_strength[s][pos] = r.strength;
      kept_x[s][pos]        = r.point_x;
      kept_y[s][pos]        = r.point_y;
   endfunction

   function automatic tkps_pkg::rsp_type next_kept_point();
      tkps_pkg::rsp_type p;
      int                sec;
      int                slt;
      p   = '0;
      sec = walk_sector;
      slt = walk_slot;
      if (!seek_kept(sec, slt)) begin
         walk_sector = NUM_SECTORS;
         walk_slot   = 0;
         return p;
      end
      p.valid_res  = 1'b1;
      p.out_x      = kept_x[sec][slt];
      p.out_y      = kept_y[sec][slt];
      p.out_sector = sec[tkps_pkg::SECTOR_W-1:0];
      slt++;
      if (slt >= KEEP_PER_SECTOR) begin
         sec++;
         slt = 0;
      end
      walk_sector = sec;
      walk_slot   = slt;
      p.last      = !seek_kept(sec, slt);
      return p;
   endfunction

   function automatic void apply_request(input tkps_pkg::req_type r);
      requests++;
      case (r.opcode)
         tkps_pkg::OP_CLEAR: begin
            clears++;
            clear_kept();
         end
         tkps_pkg::OP_INSERT: begin
            inserts++;
            rank_candidate(r);
         end
         tkps_pkg::OP_READ: begin
            reads++;
            newest_point    = next_kept_point();
            expected_points = {expected_points, newest_point};
         end
         default: ;
      endcase
   endfunction

   function automatic tkps_pkg::req_type make_request(
         input logic [tkps_pkg::OPCODE_W-1:0] op, input int sector,
         input int strength, input int x, input int y);
      tkps_pkg::req_type r;
      r.opcode   = op;
      r.sector   = sector[tkps_pkg::SECTOR_W-1:0];
      r.strength = strength[tkps_pkg::STRENGTH_W-1:0];
      r.point_x  = x[tkps_pkg::POINT_W-1:0];
      r.point_y  = y[tkps_pkg::POINT_W-1:0];
      return r;
   endfunction

   function automatic tkps_pkg::req_type noise_request(
         input logic [tkps_pkg::OPCODE_W-1:0] op);
      return make_request(op, $urandom_range(0, 63), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
   endfunction

   task automatic send_request(input tkps_pkg::req_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      apply_request(r);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
      end
   endtask

   task automatic send_op(input logic [tkps_pkg::OPCODE_W-1:0] op);
      send_request(noise_request(op));
   endtask

   task automatic send_insert(input int sector, input int strength, input int x, input int y);
      send_request(make_request(tkps_pkg::OP_INSERT, sector, strength, x, y));
   endtask

   always @(posedge clock) begin
      tkps_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_points.size() == 0) begin
            $error("unexpected response: %p", rsp_data);
            mismatches++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.valid_res) points_seen++; else empty_seen++;
            if (rsp_data.valid_res !== want.valid_res) begin
               $error("valid_res: expected %0d, got %0d", want.valid_res, rsp_data.valid_res);
               mismatches++;
            end
            if (rsp_data.out_x !== want.out_x) begin
               $error("out_x: expected %0d, got %0d", want.out_x, rsp_data.out_x);
               mismatches++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $error("out_y: expected %0d, got %0d", want.out_y, rsp_data.out_y);
               mismatches++;
            end
            if (rsp_data.out_sector !== want.out_sector) begin
               $error("out_sector: expected %0d, got %0d", want.out_sector,
                      rsp_data.out_sector);
               mismatches++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               mismatches++;
            end
         end
      end
   end

   task automatic test_empty_reads();
      send_op(tkps_pkg::OP_CLEAR);
      send_op(tkps_pkg::OP_READ);
      send_op(tkps_pkg::OP_READ);
   endtask

   task automatic test_ranking_and_ties();
      send_insert(0, 65535, 32767, -32768);
      send_insert(0, 65535, -32768, 32767);
      send_insert(0, 0, -1, 0);
      send_insert(47, 100, 0, -1);
   endtask

   task automatic test_full_sector();
      send_insert(0, 5, 1234, -1234);
      send_insert(0, 0, 7, 7);
      send_insert(0, 1, 21845, -21846);
   endtask

   task automatic test_sector_range();
      send_insert(48, 65535, 11, 11);
      send_insert(63, 65535, 22, 22);
   endtask

   task automatic test_insert_while_reading();
      send_op(tkps_pkg::OP_READ);
      send_op(tkps_pkg::OP_READ);
      send_insert(0, 65535, 333, -333);
      repeat (5) send_op(tkps_pkg::OP_READ);
   endtask

   task automatic test_unused_opcode();
      send_op(OP_UNUSED);
      send_op(tkps_pkg::OP_READ);
   endtask

   task automatic test_random_traffic();
      int  target;
      int  base;
      int  span;
      int  sector;
      int  strength;
      bit  wide;
      bit  ties;
      target = requests + RANDOM_REQUESTS;
      while (requests < target) begin
         send_op(tkps_pkg::OP_CLEAR);
         wide = ($urandom_range(0, 3) == 0);
         ties = ($urandom_range(0, 2) == 0);
         base = $urandom_range(0, NUM_SECTORS - 1);
         span = $urandom_range(1, 4);
         repeat ($urandom_range(1, 40)) begin
            case ($urandom_range(0, 19)) inside
               [0:3]:   send_op(tkps_pkg::OP_READ);
               4:       send_op(OP_UNUSED);
               default: begin
                  sector = wide ? $urandom_range(0, 63) : base + $urandom_range(0, span - 1);
                  if (ties)
                     strength = $urandom_range(0, 3);
                  else if ($urandom_range(0, 9) == 0)
                     strength = ($urandom_range(0, 1) == 0) ? 0 : 65535;
                  else
                     strength = $urandom_range(0, 65535);
                  send_insert(sector, strength, $urandom_range(0, 65535),
                              $urandom_range(0, 65535));
               end
            endcase
         end
         if ($urandom_range(0, 5) != 0) begin
            do send_op(tkps_pkg::OP_READ);
            while (newest_point.valid_res && !newest_point.last);
            repeat ($urandom_range(0, 2)) send_op(tkps_pkg::OP_READ);
         end
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      newest_point = '0;
      clear_kept();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_reads();
      test_ranking_and_ties();
      test_full_sector();
      test_sector_range();
      test_insert_while_reading();
      test_unused_opcode();
      test_random_traffic();

      start <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d clears, %0d inserts, %0d reads.",
               requests, clears, inserts, reads);
      $display("Reads returned %0d kept points and %0d empty responses.",
               points_seen, empty_seen);
      if (mismatches == 0 && expected_points.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
